FILE: design/sbpw_pkg.sv
// shared types, constants and colour functions for the sprite blitter pixel writer
`timescale 1ns / 1ps

package sbpw_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgDestX    = 3'd0;
  localparam logic [2:0] CfgDestY    = 3'd1;
  localparam logic [2:0] CfgSizeX    = 3'd2;
  localparam logic [2:0] CfgSizeY    = 3'd3;
  localparam logic [2:0] CfgMode     = 3'd4;
  localparam logic [2:0] CfgClutLow  = 3'd5;
  localparam logic [2:0] CfgClutHigh = 3'd6;

  // mode flag bit positions
  localparam int unsigned ModeXDir   = 0;
  localparam int unsigned ModeYDir   = 1;
  localparam int unsigned ModeFlip   = 2;
  localparam int unsigned ModeDirect = 3;
  localparam int unsigned ModeLowOr  = 4;

  // transparent colour table entry
  localparam logic [7:0] ClutTransparent = 8'hff;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef struct packed {
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [7:0]  size_x;
    logic [7:0]  size_y;
    logic [4:0]  mode_flags;
    logic [63:0] clut_low;
    logic [63:0] clut_high;
  } cfg_t;

  // one source byte placed on the rectangle
  typedef struct packed {
    logic [7:0] src_byte;
    logic [7:0] col;
    logic [7:0] row;
    logic       blit_end;
  } item_t;

  // one pixel write
  typedef struct packed {
    logic        write_enable;
    logic [8:0]  vram_x;
    logic [7:0]  vram_y;
    logic [15:0] pixel_value;
    logic        or_into;
    logic        last_of_byte;
    logic        blit_end;
  } result_t;

  // colour byte into the high bits of each channel
  function automatic logic [15:0] high_colour(input logic [7:0] c);
    high_colour = {c[7:6], 3'b000, c[5:3], 2'b00, c[2:0], 3'b000};
  endfunction

  // colour byte into the low bits of each channel
  function automatic logic [15:0] low_colour(input logic [7:0] c);
    low_colour = {2'b00, c[7:5], 3'b000, c[4:3], 3'b000, c[2:0]};
  endfunction

endpackage

FILE: design/sbpw_regs.sv
// configuration register file
`timescale 1ns / 1ps

module sbpw_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output logic                cfg_ready_o,
  output sbpw_pkg::cfg_t      cfg_o
);
  import sbpw_pkg::*;

  cfg_t cfg_q, cfg_d;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDestX:    cfg_d.dest_x     = cfg_data_i[7:0];
        CfgDestY:    cfg_d.dest_y     = cfg_data_i[7:0];
        CfgSizeX:    cfg_d.size_x     = cfg_data_i[7:0];
        CfgSizeY:    cfg_d.size_y     = cfg_data_i[7:0];
        CfgMode:     cfg_d.mode_flags = cfg_data_i[4:0];
        CfgClutLow:  cfg_d.clut_low   = cfg_data_i;
        CfgClutHigh: cfg_d.clut_high  = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/sbpw_front.sv
// rectangle walker: places each accepted byte and advances the position
`timescale 1ns / 1ps

module sbpw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbpw_pkg::cfg_t      cfg_i,
  input  logic                push_i,
  input  logic                q_full_i,
  input  logic [7:0]          src_byte_i,
  input  logic                first_of_blit_i,
  output logic                q_push_o,
  output sbpw_pkg::item_t     item_o
);
  import sbpw_pkg::*;

  logic [7:0] cur_col_q, cur_col_d;
  logic [7:0] cur_row_q, cur_row_d;
  logic [8:0] cols_left_q, cols_left_d;
  logic [8:0] rows_left_q, rows_left_d;

  logic       xdir, ydir, reload;
  logic [7:0] base_col, base_row, col_eff, row_eff;
  logic [8:0] row_len, rect_rows, cl_eff, rl_eff, cols_next;
  logic       end_flag;

  assign q_push_o = push_i && !q_full_i;

  // position of this byte and the walk step after it
  always_comb begin
    xdir      = cfg_i.mode_flags[ModeXDir];
    ydir      = cfg_i.mode_flags[ModeYDir];
    base_col  = cfg_i.dest_x + cfg_i.size_x;
    base_row  = cfg_i.dest_y + cfg_i.size_y;
    row_len   = {1'b0, (xdir ? ~cfg_i.size_x : cfg_i.size_x)} + 9'd1;
    rect_rows = {1'b0, (ydir ? ~cfg_i.size_y : cfg_i.size_y)} + 9'd1;
    reload    = first_of_blit_i || (rows_left_q == 9'd0);
    col_eff   = reload ? base_col  : cur_col_q;
    row_eff   = reload ? base_row  : cur_row_q;
    cl_eff    = reload ? row_len   : cols_left_q;
    rl_eff    = reload ? rect_rows : rows_left_q;
    cols_next = cl_eff - 9'd1;

    cur_col_d   = xdir ? col_eff + 8'd1 : col_eff - 8'd1;
    cur_row_d   = row_eff;
    cols_left_d = cols_next;
    rows_left_d = rl_eff;
    end_flag    = 1'b0;
    // row finished
    if (cols_next == 9'd0) begin
      cur_row_d   = ydir ? row_eff + 8'd1 : row_eff - 8'd1;
      rows_left_d = rl_eff - 9'd1;
      if (rows_left_d != 9'd0) begin
        cur_col_d   = base_col;
        cols_left_d = row_len;
      end else begin
        end_flag = 1'b1;
      end
    end

    item_o.src_byte = src_byte_i;
    item_o.col      = col_eff;
    item_o.row      = row_eff;
    item_o.blit_end = end_flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      cols_left_q <= '0;
      rows_left_q <= '0;
    end else if (q_push_o) begin
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      cols_left_q <= cols_left_d;
      rows_left_q <= rows_left_d;
    end
  end

endmodule

FILE: design/sbpw_queue.sv
// short queue of placed bytes between walker and pixel writer
`timescale 1ns / 1ps

module sbpw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sbpw_pkg::item_t     item_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output sbpw_pkg::item_t     head_o
);
  import sbpw_pkg::*;

  item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/sbpw_back.sv
// pixel writer: two doubled pixel writes per byte into an output register
`timescale 1ns / 1ps

module sbpw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbpw_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  sbpw_pkg::item_t     head_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                out_valid_o,
  output sbpw_pkg::result_t   result_o
);
  import sbpw_pkg::*;

  logic    half_q, half_d;
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;

  logic       load, flip, xdir, use_high, we;
  logic [3:0] nib;
  logic [7:0] entry;
  logic [15:0] val;

  // output register takes a new write when free or being drained
  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = load && half_q;

  // colour and coordinates of the current half
  always_comb begin
    flip     = cfg_i.mode_flags[ModeFlip];
    xdir     = cfg_i.mode_flags[ModeXDir];
    use_high = (!half_q) != xdir;
    nib      = use_high ? head_i.src_byte[7:4] : head_i.src_byte[3:0];
    entry    = nib[3] ? cfg_i.clut_high[{nib[2:0], 3'b000} +: 8]
                      : cfg_i.clut_low[{nib[2:0], 3'b000} +: 8];
    we       = 1'b1;
    val      = '0;
    if (cfg_i.mode_flags[ModeDirect]) begin
      val = cfg_i.mode_flags[ModeLowOr] ? low_colour(head_i.src_byte)
                                        : high_colour(head_i.src_byte);
    end else if (entry == ClutTransparent) begin
      we = 1'b0;
    end else begin
      val = high_colour(entry);
    end

    result_d.write_enable = we;
    result_d.vram_x       = {head_i.col, half_q} ^ {9{flip}};
    result_d.vram_y       = head_i.row ^ {8{flip}};
    result_d.pixel_value  = val;
    result_d.or_into      = we && cfg_i.mode_flags[ModeDirect] && cfg_i.mode_flags[ModeLowOr];
    result_d.last_of_byte = half_q;
    result_d.blit_end     = half_q && head_i.blit_end;
  end

  // half counter and valid flag
  always_comb begin
    half_d      = half_q;
    out_valid_d = out_valid_q;
    if (load) begin
      half_d      = !half_q;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: design/sprite_blitter_pixel_writer.sv
// top level of the sprite blitter pixel writer
//
// Usage: graphics bytes of a blit enter through a queue-like port: a byte is
// transferred on a clock edge with push high and full low; first_of_blit_i
// restarts the rectangle walk from dest plus size. Each byte gives two pixel
// writes on the result port, oldest first, shown while empty is low and
// transferred on an edge with pop high. Registers are written through the
// cfg channel (index, 64-bit data) while the block is idle.
// The byte is registered in the queue and then loaded into the output register
// when that is free; the second write of a byte is loaded from the same edge
// that transfers the first. The pixel writer emits one write per cycle into
// its output register while the receiver keeps popping.
// A two-entry queue sits between the walker and the pixel writer, so bytes
// keep being taken while a result waits; when the receiver stalls, the
// queue fills and full rises.
// Reset clears the walk position, the queue, the output register valid and
// all configuration registers to zero.
`timescale 1ns / 1ps

module sprite_blitter_pixel_writer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic [7:0]   src_byte_i,
  input  logic         first_of_blit_i,
  output logic         empty,
  input  logic         pop,
  output logic         write_enable_o,
  output logic [8:0]   vram_x_o,
  output logic [7:0]   vram_y_o,
  output logic [15:0]  pixel_value_o,
  output logic         or_into_o,
  output logic         last_of_byte_o,
  output logic         blit_end_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import sbpw_pkg::*;

  cfg_t    cfg;
  item_t   item, head;
  result_t result;
  logic    q_push, q_pop, q_full, q_empty, out_valid;

  // configuration registers
  sbpw_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // rectangle walker
  sbpw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .push_i          (push),
    .q_full_i        (q_full),
    .src_byte_i      (src_byte_i),
    .first_of_blit_i (first_of_blit_i),
    .q_push_o        (q_push),
    .item_o          (item)
  );

  // queue between walker and writer
  sbpw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // pixel writer
  sbpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  // port unpacking
  assign full           = q_full;
  assign empty          = !out_valid;
  assign write_enable_o = result.write_enable;
  assign vram_x_o       = result.vram_x;
  assign vram_y_o       = result.vram_y;
  assign pixel_value_o  = result.pixel_value;
  assign or_into_o      = result.or_into;
  assign last_of_byte_o = result.last_of_byte;
  assign blit_end_o     = result.blit_end;

  // end of rectangle only on the second write of a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_of_byte_o) |-> !blit_end_o)
    else $error("blit end flagged on first write of a byte");

  // a suppressed write carries no colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !write_enable_o) |-> (pixel_value_o == 16'd0 && !or_into_o))
    else $error("disabled write carries colour");

  // second write follows the first right after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_byte_o) |=> (!empty && last_of_byte_o))
    else $error("second write of a byte missing");

endmodule
